>>> src/mshti_pkg.sv
// Shared widths, queue sizing and queue entry type for the mid-square hash table insert block.
package mshti_pkg;

   localparam int KEY_W          = 20;
   localparam int SLOT_W         = 14;
   localparam int CNT_W          = 20;
   localparam int TABLE_SIZE_DEF = 10007;
   localparam int Q_DEPTH        = 4;
   localparam int QPTR_W         = $clog2(Q_DEPTH);
   localparam int QCNT_W         = $clog2(Q_DEPTH + 1);

   typedef struct packed {
      logic [SLOT_W-1:0] slot;
      logic [KEY_W-1:0]  key;
   } qent_type;

endpackage

>>> src/mshti_front.sv
// Hash front end: squares the key in base 1000, picks the middle four decimal digits.
module mshti_front #(
   parameter int TABLE_SIZE = mshti_pkg::TABLE_SIZE_DEF
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     in_valid,
   output logic                     in_ready,
   input  logic [mshti_pkg::KEY_W-1:0] in_key,
   input  logic                     hold,
   output logic                     push,
   output mshti_pkg::qent_type      push_data,
   input  logic                     q_full
);
   import mshti_pkg::*;

   localparam int NSTG    = 13;
   localparam int BCD_DIG = 13;
   localparam int BCD_W   = 4 * BCD_DIG;
   localparam int DIV_SH  = 34;
   localparam logic [24:0] DIV_MUL = 25'd17179870;
   localparam int CMP_W   = SLOT_W + 1;
   localparam logic [CMP_W-1:0] TBL = CMP_W'(TABLE_SIZE);

   // x / 1000 for x below 4096000, by reciprocal multiply
   function automatic logic [11:0] div1000(input logic [23:0] x);
      logic [48:0] prod;
      prod = 49'(x) * 49'(DIV_MUL);
      return prod[DIV_SH+11:DIV_SH];
   endfunction

   // three BCD digits of a value below 1000
   function automatic logic [11:0] bcd3(input logic [9:0] d);
      logic [15:0] hp;
      logic [3:0]  h;
      logic [6:0]  r;
      logic [13:0] tp;
      logic [3:0]  t;
      logic [3:0]  o;
      hp = 16'(d) * 16'd41;
      h  = hp[15:12];
      r  = 7'(d - 10'(h) * 10'd100);
      tp = 14'(r) * 14'd103;
      t  = tp[13:10];
      o  = 4'(r - 7'(t) * 7'd10);
      return {h, t, o};
   endfunction

   logic [NSTG-1:0]  vld_ff;
   logic [KEY_W-1:0] key_ff [NSTG];

   logic [10:0] kh_s2_ff, kh_s3_ff;
   logic [9:0]  kl_s3_ff;
   logic [20:0] p2_s4_ff, p2_s5_ff, p2_s6_ff, p2_s7_ff;
   logic [21:0] p1_s4_ff, p1_s5_ff;
   logic [19:0] p0_s4_ff, p0_s5_ff;
   logic [9:0]  c0_s5_ff;
   logic [9:0]  d0_s6_ff, d0_s7_ff, d0_s8_ff, d0_s9_ff, d0_s10_ff;
   logic [21:0] t1_s6_ff, t1_s7_ff;
   logic [11:0] c1_s7_ff;
   logic [9:0]  d1_s8_ff, d1_s9_ff, d1_s10_ff;
   logic [20:0] t2_s8_ff, t2_s9_ff;
   logic [10:0] c2_s9_ff, c2_s10_ff;
   logic [9:0]  d2_s10_ff;
   logic [BCD_W-1:0]  bcd_s11_ff;
   logic [15:0]       mid_s12_ff;
   logic [SLOT_W-1:0] slot_s13_ff;

   logic              adv;
   logic              c2_th;
   logic [9:0]        c2_rem;
   logic [BCD_W-1:0]  bcd_in;
   logic [3:0]        msd;
   logic [2:0]        drop;
   logic [15:0]       mid_in;
   logic [SLOT_W-1:0] mid_bin;
   logic [SLOT_W-1:0] slot_in;

   assign adv       = !vld_ff[NSTG-1] || !q_full;
   assign in_ready  = adv && !hold;
   assign push      = vld_ff[NSTG-1] && !q_full;
   assign push_data = '{slot: slot_s13_ff, key: key_ff[NSTG-1]};

   always_comb begin
      c2_th  = (c2_s10_ff >= 11'd1000);
      c2_rem = 10'(c2_s10_ff - (c2_th ? 11'd1000 : 11'd0));
      bcd_in = {3'b000, c2_th, bcd3(c2_rem), bcd3(d2_s10_ff), bcd3(d1_s10_ff),
                bcd3(d0_s10_ff)};
   end

   // leading digit position sets how many low digits are dropped
   always_comb begin
      msd = '0;
      for (int i = 0; i < BCD_DIG; i++) begin
         if (bcd_s11_ff[4*i +: 4] != 4'd0) begin
            msd = 4'(i);
         end
      end
      if (msd < 4'd4) begin
         drop = '0;
      end else begin
         drop = 3'((msd - 4'd2) >> 1);
      end
      mid_in = 16'(bcd_s11_ff >> (6'(drop) * 6'd4));
   end

   always_comb begin
      mid_bin = 14'(mid_s12_ff[15:12]) * 14'd1000 + 14'(mid_s12_ff[11:8]) * 14'd100
              + 14'(mid_s12_ff[7:4]) * 14'd10 + 14'(mid_s12_ff[3:0]);
      if (CMP_W'(mid_bin) >= TBL) begin
         slot_in = SLOT_W'(CMP_W'(mid_bin) - TBL);
      end else begin
         slot_in = mid_bin;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
      end else if (adv) begin
         vld_ff <= {vld_ff[NSTG-2:0], in_valid && in_ready};
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         key_ff[0] <= in_key;
         for (int i = 1; i < NSTG; i++) begin
            key_ff[i] <= key_ff[i-1];
         end
         kh_s2_ff  <= 11'(div1000(24'(key_ff[0])));
         kh_s3_ff  <= kh_s2_ff;
         kl_s3_ff  <= 10'(key_ff[1] - 20'(kh_s2_ff) * 20'd1000);
         p2_s4_ff  <= 21'(kh_s3_ff) * 21'(kh_s3_ff);
         p1_s4_ff  <= {21'(kh_s3_ff) * 21'(kl_s3_ff), 1'b0};
         p0_s4_ff  <= 20'(kl_s3_ff) * 20'(kl_s3_ff);
         p2_s5_ff  <= p2_s4_ff;
         p1_s5_ff  <= p1_s4_ff;
         p0_s5_ff  <= p0_s4_ff;
         c0_s5_ff  <= 10'(div1000(24'(p0_s4_ff)));
         p2_s6_ff  <= p2_s5_ff;
         d0_s6_ff  <= 10'(p0_s5_ff - 20'(c0_s5_ff) * 20'd1000);
         t1_s6_ff  <= p1_s5_ff + 22'(c0_s5_ff);
         p2_s7_ff  <= p2_s6_ff;
         d0_s7_ff  <= d0_s6_ff;
         t1_s7_ff  <= t1_s6_ff;
         c1_s7_ff  <= div1000(24'(t1_s6_ff));
         d0_s8_ff  <= d0_s7_ff;
         d1_s8_ff  <= 10'(t1_s7_ff - 22'(c1_s7_ff) * 22'd1000);
         t2_s8_ff  <= p2_s7_ff + 21'(c1_s7_ff);
         d0_s9_ff  <= d0_s8_ff;
         d1_s9_ff  <= d1_s8_ff;
         t2_s9_ff  <= t2_s8_ff;
         c2_s9_ff  <= 11'(div1000(24'(t2_s8_ff)));
         d0_s10_ff <= d0_s9_ff;
         d1_s10_ff <= d1_s9_ff;
         d2_s10_ff <= 10'(t2_s9_ff - 21'(c2_s9_ff) * 21'd1000);
         c2_s10_ff <= c2_s9_ff;
         bcd_s11_ff  <= bcd_in;
         mid_s12_ff  <= mid_in;
         slot_s13_ff <= slot_in;
      end
   end

endmodule

>>> src/mshti_queue.sv
// Small queue of hashed items between the front end and the table engine.
module mshti_queue (
   input  logic                clock,
   input  logic                reset,
   input  logic                push,
   input  mshti_pkg::qent_type push_data,
   output logic                full,
   input  logic                pop,
   output logic                head_valid,
   output mshti_pkg::qent_type head_data
);
   import mshti_pkg::*;

   qent_type          ent_ff [Q_DEPTH];
   logic [QPTR_W-1:0] wp_ff, wp_in;
   logic [QPTR_W-1:0] rp_ff, rp_in;
   logic [QCNT_W-1:0] cnt_ff, cnt_in;
   logic              do_push;
   logic              do_pop;

   assign full       = (cnt_ff == QCNT_W'(Q_DEPTH));
   assign head_valid = (cnt_ff != '0);
   assign head_data  = ent_ff[rp_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   always_comb begin
      wp_in  = wp_ff;
      rp_in  = rp_ff;
      cnt_in = cnt_ff;
      if (do_push) begin
         wp_in = (wp_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : wp_ff + 1'b1;
      end
      if (do_pop) begin
         rp_in = (rp_ff == QPTR_W'(Q_DEPTH - 1)) ? '0 : rp_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wp_ff  <= '0;
         rp_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wp_ff  <= wp_in;
         rp_ff  <= rp_in;
         cnt_ff <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         ent_ff[wp_ff] <= push_data;
      end
   end

endmodule

>>> src/mshti_back.sv
// Table engine: clears the table after reset, then read-modify-writes one slot per item.
module mshti_back #(
   parameter int TABLE_SIZE = mshti_pkg::TABLE_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         head_valid,
   input  mshti_pkg::qent_type          head_data,
   output logic                         pop,
   output logic                         clearing,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mshti_pkg::SLOT_W-1:0] rsp_slot,
   output logic                         rsp_inserted,
   output logic [mshti_pkg::KEY_W-1:0]  rsp_occupant,
   output logic [mshti_pkg::CNT_W-1:0]  rsp_collision_total,
   output logic [mshti_pkg::CNT_W-1:0]  rsp_insert_total
);
   import mshti_pkg::*;

   localparam int ADDR_W = $clog2(TABLE_SIZE);
   localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(TABLE_SIZE - 1);

   typedef enum logic [2:0] {
      ST_CLEAR = 3'b001,
      ST_IDLE  = 3'b010,
      ST_LOOK  = 3'b100
   } st_type;

   logic [KEY_W-1:0]  tbl_mem [TABLE_SIZE];

   st_type            st_ff, st_in;
   logic [ADDR_W-1:0] clr_ff, clr_in;
   logic [SLOT_W-1:0] cur_slot_ff;
   logic [KEY_W-1:0]  cur_key_ff;
   logic [KEY_W-1:0]  rd_data_ff;
   logic [CNT_W-1:0]  ins_cnt_ff, ins_cnt_in;
   logic [CNT_W-1:0]  col_cnt_ff, col_cnt_in;
   logic              rsp_valid_ff;
   logic [SLOT_W-1:0] rsp_slot_ff;
   logic              rsp_inserted_ff;
   logic [KEY_W-1:0]  rsp_occupant_ff;

   logic              rd_en;
   logic [ADDR_W-1:0] rd_addr;
   logic              wr_en;
   logic [ADDR_W-1:0] wr_addr;
   logic [KEY_W-1:0]  wr_data;
   logic              load;
   logic              empty_hit;

   assign empty_hit = (rd_data_ff == '0);
   assign clearing  = (st_ff == ST_CLEAR);

   always_comb begin
      st_in   = st_ff;
      clr_in  = clr_ff;
      pop     = 1'b0;
      rd_en   = 1'b0;
      rd_addr = ADDR_W'(head_data.slot);
      wr_en   = 1'b0;
      wr_addr = clr_ff;
      wr_data = '0;
      load    = 1'b0;
      unique case (st_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_ff == LAST_ADDR) begin
               st_in = ST_IDLE;
            end else begin
               clr_in = clr_ff + 1'b1;
            end
         end
         ST_IDLE: begin
            if (head_valid) begin
               pop   = 1'b1;
               rd_en = 1'b1;
               st_in = ST_LOOK;
            end
         end
         ST_LOOK: begin
            if (!rsp_valid_ff || rsp_ready) begin
               load  = 1'b1;
               st_in = ST_IDLE;
               if (empty_hit) begin
                  wr_en   = 1'b1;
                  wr_addr = ADDR_W'(cur_slot_ff);
                  wr_data = cur_key_ff;
               end
            end
         end
         default: begin
            st_in = ST_CLEAR;
         end
      endcase
   end

   always_comb begin
      ins_cnt_in = ins_cnt_ff;
      col_cnt_in = col_cnt_ff;
      if (empty_hit) begin
         if (ins_cnt_ff != '1) begin
            ins_cnt_in = ins_cnt_ff + 1'b1;
         end
      end else begin
         if (col_cnt_ff != '1) begin
            col_cnt_in = col_cnt_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff        <= ST_CLEAR;
         clr_ff       <= '0;
         ins_cnt_ff   <= '0;
         col_cnt_ff   <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         st_ff  <= st_in;
         clr_ff <= clr_in;
         if (load) begin
            ins_cnt_ff   <= ins_cnt_in;
            col_cnt_ff   <= col_cnt_in;
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (pop) begin
         cur_slot_ff <= head_data.slot;
         cur_key_ff  <= head_data.key;
      end
      if (load) begin
         rsp_slot_ff     <= cur_slot_ff;
         rsp_inserted_ff <= empty_hit;
         rsp_occupant_ff <= empty_hit ? '0 : rd_data_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         tbl_mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= tbl_mem[rd_addr];
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_slot            = rsp_slot_ff;
   assign rsp_inserted        = rsp_inserted_ff;
   assign rsp_occupant        = rsp_occupant_ff;
   assign rsp_collision_total = col_cnt_ff;
   assign rsp_insert_total    = ins_cnt_ff;

endmodule

>>> src/midsquare_hash_table_insert_top.sv
// Path from item acceptance to result valid: 13-stage hash pipe, queue, table engine.
// The table engine takes a new item only after it has finished the read-modify-write of the last one.
// The hash pipe and the 4-entry queue keep taking items while the table engine or rsp stalls, until the queue fills.
// Reset: synchronous, active high; counters clear, then the table is cleared one entry per
// cycle, all TABLE_SIZE entries (10007 by default), while req_ready stays low.
module midsquare_hash_table_insert_top #(
   parameter int TABLE_SIZE = mshti_pkg::TABLE_SIZE_DEF
) (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         req_valid,
   output logic                         req_ready,
   input  logic [mshti_pkg::KEY_W-1:0]  req_key,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output logic [mshti_pkg::SLOT_W-1:0] rsp_slot,
   output logic                         rsp_inserted,
   output logic [mshti_pkg::KEY_W-1:0]  rsp_occupant,
   output logic [mshti_pkg::CNT_W-1:0]  rsp_collision_total,
   output logic [mshti_pkg::CNT_W-1:0]  rsp_insert_total
);
   import mshti_pkg::*;

   logic     push;
   qent_type push_data;
   logic     q_full;
   logic     pop;
   logic     head_valid;
   qent_type head_data;
   logic     clearing;

   mshti_front #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (req_valid),
      .in_ready  (req_ready),
      .in_key    (req_key),
      .hold      (clearing),
      .push      (push),
      .push_data (push_data),
      .q_full    (q_full)
   );

   mshti_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_data  (push_data),
      .full       (q_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_data  (head_data)
   );

   mshti_back #(
      .TABLE_SIZE(TABLE_SIZE)
   ) u_back (
      .clock               (clock),
      .reset               (reset),
      .head_valid          (head_valid),
      .head_data           (head_data),
      .pop                 (pop),
      .clearing            (clearing),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_slot            (rsp_slot),
      .rsp_inserted        (rsp_inserted),
      .rsp_occupant        (rsp_occupant),
      .rsp_collision_total (rsp_collision_total),
      .rsp_insert_total    (rsp_insert_total)
   );

endmodule

>>> test/tb_midsquare_hash_table_insert_top.sv
// Self-checking testbench for the mid-square hash table insert block.
`timescale 1ns / 1ps

module tb_midsquare_hash_table_insert_top;
   import mshti_pkg::*;

   localparam int TBL         = TABLE_SIZE_DEF;
   localparam int CNT_MAX     = (1 << CNT_W) - 1;
   localparam int STALL_LIMIT = 30000;
   localparam int RANDOM_KEYS = 600;

   typedef struct {
      logic [SLOT_W-1:0] slot;
      logic              inserted;
      logic [KEY_W-1:0]  occupant;
      logic [CNT_W-1:0]  collision_total;
      logic [CNT_W-1:0]  insert_total;
   } table_outcome_type;

   logic                clock;
   logic                reset;
   logic                req_valid;
   logic                req_ready;
   logic [KEY_W-1:0]    req_key;
   logic                rsp_valid;
   logic                rsp_ready;
   logic [SLOT_W-1:0]   rsp_slot;
   logic                rsp_inserted;
   logic [KEY_W-1:0]    rsp_occupant;
   logic [CNT_W-1:0]    rsp_collision_total;
   logic [CNT_W-1:0]    rsp_insert_total;

   logic [KEY_W-1:0]    shadow_slots [TBL];
   logic [CNT_W-1:0]    collision_tally;
   logic [CNT_W-1:0]    insert_tally;
   table_outcome_type   outcome_q [$];
   logic [KEY_W-1:0]    sent_keys [$];
   int                  fault_count;
   int                  rsp_hold_left;
   int                  stall_cycles;
   bit                  quiet_mode;

   midsquare_hash_table_insert_top dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_key             (req_key),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_slot            (rsp_slot),
      .rsp_inserted        (rsp_inserted),
      .rsp_occupant        (rsp_occupant),
      .rsp_collision_total (rsp_collision_total),
      .rsp_insert_total    (rsp_insert_total)
   );

   always begin
      clock = 1'b0;
      #5;
      clock = 1'b1;
      #5;
   end

   // middle four decimal digits of key^2, zero-padded to four digits, modulo the table size
   function automatic logic [SLOT_W-1:0] hash_slot(input logic [KEY_W-1:0] key);
      longint unsigned sq;
      longint unsigned t;
      int              digits;
      int              drop;
      sq = key;
      sq = sq * sq;
      t = sq;
      digits = 1;
      while (t >= 10) begin
         t = t / 10;
         digits++;
      end
      if (digits < 4) digits = 4;
      drop = digits - (digits - 4) / 2 - 4;
      t = sq;
      for (int i = 0; i < drop; i++) t = t / 10;
      t = (t % 10000) % TBL;
      return SLOT_W'(t);
   endfunction

   function automatic table_outcome_type predict_insert(input logic [KEY_W-1:0] key);
      table_outcome_type o;
      logic [SLOT_W-1:0] s;
      s = hash_slot(key);
      o.slot = s;
      if (shadow_slots[s] == '0) begin
         shadow_slots[s] = key;
         o.inserted = 1'b1;
         o.occupant = '0;
         if (insert_tally != CNT_MAX) insert_tally = insert_tally + 1'b1;
      end else begin
         o.inserted = 1'b0;
         o.occupant = shadow_slots[s];
         if (collision_tally != CNT_MAX) collision_tally = collision_tally + 1'b1;
      end
      o.collision_total = collision_tally;
      o.insert_total = insert_tally;
      return o;
   endfunction

   task automatic send_key(input logic [KEY_W-1:0] key);
      @(negedge clock);
      while (!quiet_mode && $urandom_range(0, 99) < 15) begin
         req_valid <= 1'b0;
         req_key   <= KEY_W'($urandom);
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_key   <= key;
      do begin
         @(posedge clock);
      end while (!req_ready);
      outcome_q.push_back(predict_insert(key));
      sent_keys.push_back(key);
   endtask

   task automatic wait_for_drain();
      @(negedge clock);
      req_valid <= 1'b0;
      while (outcome_q.size() != 0) @(posedge clock);
   endtask

   function automatic logic [KEY_W-1:0] pick_key();
      int r;
      r = $urandom_range(0, 99);
      if (r < 35 && sent_keys.size() != 0)
         return sent_keys[$urandom_range(0, sent_keys.size() - 1)];
      else if (r < 45)
         return KEY_W'($urandom_range(0, 200));
      else if (r < 55)
         return KEY_W'($urandom_range(1000000, CNT_MAX));
      return KEY_W'($urandom_range(0, 999999));
   endfunction

   // zero key, slot-0 sharing, short squares, range ends, repeats
   task automatic test_directed();
      logic [KEY_W-1:0] keys [$];
      keys = '{20'd0, 20'd1000, 20'd0, 20'd1, 20'd2, 20'd31, 20'd32, 20'd99, 20'd100,
               20'd1, 20'd999999, 20'd1000000, 20'd1048575, 20'd1048575, 20'd524288,
               20'd12345, 20'd1000, 20'd31};
      foreach (keys[i]) send_key(keys[i]);
   endtask

   task automatic test_backpressure();
      rsp_hold_left = 200;
      repeat (25) send_key(pick_key());
   endtask

   task automatic test_drain_pause();
      repeat (10) send_key(pick_key());
      wait_for_drain();
      repeat (10) send_key(pick_key());
   endtask

   task automatic test_random();
      for (int n = 0; n < RANDOM_KEYS; n++) begin
         quiet_mode = (n >= 200 && n < 300);
         send_key(pick_key());
      end
      quiet_mode = 1'b0;
   endtask

   always @(negedge clock) begin
      if (rsp_hold_left > 0) begin
         rsp_ready <= 1'b0;
         rsp_hold_left = rsp_hold_left - 1;
      end else if (quiet_mode) begin
         rsp_ready <= 1'b1;
      end else begin
         rsp_ready <= ($urandom_range(0, 99) >= 15);
      end
   end

   always @(posedge clock) begin
      table_outcome_type e;
      if (!reset && rsp_valid && rsp_ready) begin
         if (outcome_q.size() == 0) begin
            fault_count++;
            if (fault_count <= 10)
               $display("%0t: unexpected item slot=%0d", $realtime, rsp_slot);
         end else begin
            e = outcome_q.pop_front();
            if (rsp_slot !== e.slot || rsp_inserted !== e.inserted ||
                rsp_occupant !== e.occupant || rsp_collision_total !== e.collision_total ||
                rsp_insert_total !== e.insert_total) begin
               fault_count++;
               if (fault_count <= 10) begin
                  $write("%0t: mismatch exp slot=%0d ins=%0d occ=%0d col=%0d tot=%0d",
                         $realtime, e.slot, e.inserted, e.occupant, e.collision_total,
                         e.insert_total);
                  $display(" got %0d %0d %0d %0d %0d", rsp_slot, rsp_inserted,
                           rsp_occupant, rsp_collision_total, rsp_insert_total);
               end
            end
         end
      end
   end

   always @(posedge clock) begin
      if ((req_valid && req_ready) || (rsp_valid && rsp_ready))
         stall_cycles <= 0;
      else
         stall_cycles <= stall_cycles + 1;
      if (stall_cycles >= STALL_LIMIT) begin
         $display("DONE: errors detected");
         $finish;
      end
   end

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_key = '0;
      rsp_ready = 1'b0;
      rsp_hold_left = 0;
      quiet_mode = 1'b0;
      fault_count = 0;
      stall_cycles = 0;
      collision_tally = '0;
      insert_tally = '0;
      foreach (shadow_slots[i]) shadow_slots[i] = '0;
      repeat (11) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      test_directed();
      test_backpressure();
      test_drain_pause();
      test_random();

      wait_for_drain();
      repeat (30) @(posedge clock);
      if (fault_count == 0 && outcome_q.size() == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> files.f
src/mshti_pkg.sv
src/mshti_front.sv
src/mshti_queue.sv
src/mshti_back.sv
src/midsquare_hash_table_insert_top.sv
test/tb_midsquare_hash_table_insert_top.sv
